### src/wsfr_pkg.sv
// Package for the WebSocket frame receiver: beat structs, status and kind
// codes, close codes and the status-to-close-code decoder.
// No dependencies.
`timescale 1ns / 1ps

package wsfr_pkg;

  // Position counter width and its saturation value
  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // Header lengths for 7-bit and 16-bit payload length forms
  localparam logic [3:0] HdrShort = 4'd6;
  localparam logic [3:0] HdrExt   = 4'd8;

  // Length field codes and limits
  localparam logic [6:0]  LenExt16   = 7'd126;
  localparam logic [6:0]  LenExt64   = 7'd127;
  localparam logic [15:0] ExtLenMin  = 16'd126;
  localparam logic [PosW-1:0] ExtSegMin = 17'd134;

  // Header bit masks
  localparam logic [7:0] RsvMask = 8'b0111_0000;

  // Opcodes
  localparam logic [3:0] OpContinue = 4'h0;
  localparam logic [3:0] OpText     = 4'h1;
  localparam logic [3:0] OpBinary   = 4'h2;
  localparam logic [3:0] OpClose    = 4'h8;
  localparam logic [3:0] OpPing     = 4'h9;

  // Reserved opcode ranges: non-control and control
  localparam logic [3:0] OpRsvDataLo = 4'h3;
  localparam logic [3:0] OpRsvDataHi = 4'h7;
  localparam logic [3:0] OpRsvCtrlLo = 4'hB;
  localparam logic [3:0] OpRsvCtrlHi = 4'hF;

  // Close codes
  localparam logic [15:0] CloseNormal   = 16'd1000;
  localparam logic [15:0] CloseProtocol = 16'd1002;
  localparam logic [15:0] CloseBadData  = 16'd1003;
  localparam logic [15:0] CloseTooBig   = 16'd1009;
  localparam logic [15:0] CloseNone     = 16'd0;

  typedef enum logic [1:0] {
    KIND_MESSAGE = 2'd0,
    KIND_PONG    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_NEED_MORE     = 4'd1,
    ST_TOO_SMALL     = 4'd2,
    ST_RSV_BITS      = 4'd3,
    ST_FIN_CLEAR     = 4'd4,
    ST_RSV_OPCODE    = 4'd5,
    ST_UNEXP_OPCODE  = 4'd6,
    ST_UNMASKED      = 4'd7,
    ST_TOO_BIG       = 4'd8,
    ST_LONG_CONTROL  = 4'd9,
    ST_LEN_MISMATCH  = 4'd10,
    ST_ZERO_MASK     = 4'd11
  } status_e;

  // One received byte with its side-band
  typedef struct packed {
    logic [7:0]      rx_byte;
    logic            first_byte;
    logic            last_byte;
    logic [PosW-1:0] segment_length;
    logic            closing;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    status_e     status;
    logic [15:0] disconnect_code;
    logic [15:0] peer_code;
    logic        report_error;
    logic [7:0]  pong_length;
    logic        verdict_last;
  } result_t;

  // Results of one byte: zero, one or two beats, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    beat0;
    result_t    beat1;
  } push_t;

  // Close code requested for a verdict status
  function automatic logic [15:0] code_for(status_e st);
    logic [15:0] code;
    unique case (st) inside
      ST_OK, ST_NEED_MORE:     code = CloseNone;
      ST_FIN_CLEAR, ST_TOO_BIG: code = CloseTooBig;
      ST_UNEXP_OPCODE:         code = CloseBadData;
      default:                 code = CloseProtocol;
    endcase
    return code;
  endfunction

endpackage

### src/wsfr_parser.sv
// Frame parser: per-segment header state, checks, payload unmasking and
// verdict generation for one byte per cycle while fire_i is set.
// Depends on wsfr_pkg.
`timescale 1ns / 1ps

module wsfr_parser
  import wsfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_beat_t in_i,
  output push_t    push_o
);

  logic [PosW-1:0] pos_q, pos_d, pos;
  logic [3:0]      op_q, op_d, op;
  logic [6:0]      short_q, short_d, short_len;
  logic [15:0]     ext_q, ext_d, ext_len;
  logic [31:0]     mask_q, mask_d, mask_key;
  status_e         err_q, err_d, err;
  logic [15:0]     peer_q, peer_d, peer;
  logic [PosW-1:0] total_q, total_d, total;
  logic            closing_q, closing_d, closing;

  logic [3:0]      hdr, hdr_n;
  logic [PosW-1:0] idx;
  logic [7:0]      key_byte, unmasked;
  logic            emit_pay;
  kind_e           pay_kind;
  result_t         pay_beat, verdict_beat;
  logic [15:0]     disc;
  logic [7:0]      pong;
  logic [7:0]      b;

  assign b = in_i.rx_byte;

  // Parse one byte
  always_comb begin
    // a first byte restarts the segment state
    pos       = in_i.first_byte ? '0 : pos_q;
    op        = in_i.first_byte ? OpContinue : op_q;
    short_len = in_i.first_byte ? '0 : short_q;
    ext_len   = in_i.first_byte ? '0 : ext_q;
    mask_key  = in_i.first_byte ? '0 : mask_q;
    err       = in_i.first_byte ? ST_OK : err_q;
    peer      = in_i.first_byte ? CloseNormal : peer_q;
    total     = in_i.first_byte ? in_i.segment_length : total_q;
    closing   = in_i.first_byte ? in_i.closing : closing_q;

    hdr = (short_len == LenExt16) ? HdrExt : HdrShort;
    idx = pos - PosW'(hdr);

    op_d      = op;
    short_d   = short_len;
    ext_d     = ext_len;
    mask_d    = mask_key;
    err_d     = err;
    peer_d    = peer;
    total_d   = total;
    closing_d = closing;

    case (idx[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    unmasked = b ^ key_byte;
    emit_pay = 1'b0;
    pay_kind = KIND_MESSAGE;

    if (err == ST_OK) begin
      if (pos == '0) begin
        // FIN, reserved bits, opcode
        op_d = b[3:0];
        if (total < PosW'(HdrShort)) err_d = ST_TOO_SMALL;
        else if ((b & RsvMask) != '0) err_d = ST_RSV_BITS;
        else if (!b[7]) err_d = ST_FIN_CLEAR;
        else if (b[3:0] inside {[OpRsvDataLo:OpRsvDataHi],
                                [OpRsvCtrlLo:OpRsvCtrlHi]}) err_d = ST_RSV_OPCODE;
        else if (b[3:0] == OpContinue || b[3:0] == OpText) err_d = ST_UNEXP_OPCODE;
      end else if (pos == PosW'(1)) begin
        // mask bit and 7-bit length
        short_d = b[6:0];
        if (!b[7]) err_d = ST_UNMASKED;
        else if (b[6:0] == LenExt64) err_d = ST_TOO_BIG;
        else if (b[6:0] == LenExt16) begin
          if (op != OpBinary) err_d = ST_LONG_CONTROL;
          else if (total < ExtSegMin) err_d = ST_NEED_MORE;
        end
      end else if (hdr == HdrExt && pos < PosW'(4)) begin
        // 16-bit extended length, high byte first
        ext_d = {ext_len[7:0], b};
        if (pos == PosW'(3) && (ext_d < ExtLenMin ||
            total < PosW'(ext_d) + PosW'(HdrExt)))
          err_d = ST_LEN_MISMATCH;
      end else if (pos < PosW'(hdr)) begin
        // masking key, high byte first
        mask_d = {mask_key[23:0], b};
        if (pos == PosW'(hdr - 4'd1) && mask_d == '0) err_d = ST_ZERO_MASK;
      end else begin
        // payload byte
        if (op == OpBinary && !closing) begin
          emit_pay = 1'b1;
        end else if (op == OpPing && !closing) begin
          emit_pay = 1'b1;
          pay_kind = KIND_PONG;
        end
        if (op == OpClose && total >= PosW'(hdr) + PosW'(2)) begin
          if (idx == '0) peer_d = {unmasked, 8'h00};
          else if (idx == PosW'(1)) peer_d = {peer[15:8], unmasked};
        end
      end
    end

    pos_d = (pos == PosMax) ? pos : pos + PosW'(1);

    // verdict on the final byte
    hdr_n = (short_d == LenExt16) ? HdrExt : HdrShort;
    if (in_i.last_byte && err_d == ST_OK && pos_d < PosW'(hdr_n)) err_d = ST_TOO_SMALL;

    disc = CloseNone;
    pong = '0;
    if (err_d != ST_OK) disc = code_for(err_d);
    else if (op_d == OpClose) disc = CloseNormal;
    else if (op_d == OpPing && !closing) pong = 8'(total - PosW'(hdr_n));

    pay_beat = '{kind: pay_kind, out_byte: unmasked, status: ST_OK,
                 disconnect_code: '0, peer_code: '0,
                 report_error: 1'b0, pong_length: '0, verdict_last: 1'b0};
    verdict_beat = '{kind: KIND_VERDICT, out_byte: '0, status: err_d,
                     disconnect_code: disc, peer_code: peer_d,
                     report_error: (err_d == ST_OK && op_d == OpClose &&
                                    peer_d != CloseNormal),
                     pong_length: pong, verdict_last: 1'b1};

    push_o.count = 2'(emit_pay) + 2'(in_i.last_byte);
    push_o.beat0 = emit_pay ? pay_beat : verdict_beat;
    push_o.beat1 = verdict_beat;
  end

  // Segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      op_q      <= OpContinue;
      short_q   <= '0;
      ext_q     <= '0;
      mask_q    <= '0;
      err_q     <= ST_OK;
      peer_q    <= CloseNormal;
      total_q   <= '0;
      closing_q <= 1'b0;
    end else if (fire_i) begin
      pos_q     <= pos_d;
      op_q      <= op_d;
      short_q   <= short_d;
      ext_q     <= ext_d;
      mask_q    <= mask_d;
      err_q     <= err_d;
      peer_q    <= peer_d;
      total_q   <= total_d;
      closing_q <= closing_d;
    end
  end

endmodule

### src/wsfr_out_fifo.sv
// Four-entry result queue: takes up to two beats per cycle from the
// parser, hands one beat per cycle to the output stream while it is ready.
// Depends on wsfr_pkg.
`timescale 1ns / 1ps

module wsfr_out_fifo
  import wsfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_en_i,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  result_t         entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic [1:0]      n_push;
  logic            pop;

  assign n_push      = push_en_i ? push_i.count : 2'd0;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = entry_q[rptr_q];
  // room for a full two-beat push
  assign room_o      = (count_q <= (PtrW+1)'(Depth - 2));

  // Pointer and fill count
  always_comb begin
    wptr_d  = wptr_q + PtrW'(n_push);
    rptr_d  = rptr_q + PtrW'(pop);
    count_d = count_q + (PtrW+1)'(n_push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) entry_q[wptr_q] <= push_i.beat0;
    if (n_push == 2'd2) entry_q[wptr_q + PtrW'(1)] <= push_i.beat1;
  end

endmodule

### src/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver: input beat register, parser
// and result queue. Depends on wsfr_pkg, wsfr_parser and wsfr_out_fifo.
`timescale 1ns / 1ps

// Takes one segment byte per beat and one beat per clock cycle. Each byte
// passes an input register, is parsed combinationally and is written into a
// four-entry result queue, from which its results are offered on the
// output. A byte gives at most two result beats (a payload byte and the
// verdict on the final byte); the queue drains one beat per cycle while the
// sink is ready, so with an always-ready sink the final byte of a segment
// that streams payload leaves one extra beat in the queue, and input
// throughput is otherwise one byte per cycle. Input is held off only while
// the queue lacks room for two beats.
module websocket_frame_receiver
  import wsfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [24:8] segment_length, [25] closing, [31:26] zero
  input  logic [31:0] s_axis_tdata,
  // [0] first_byte
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [11:8] status, [27:12] disconnect_code,
  // [43:28] peer_code, [44] report_error, [52:45] pong_length,
  // [55:53] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  in_beat_t in_q;
  logic     in_valid_q, in_valid_d;
  logic     s_accept, fire, room;
  push_t    push;
  result_t  res;

  // Input beat register
  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_accept || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.rx_byte        <= s_axis_tdata[7:0];
      in_q.first_byte     <= s_axis_tuser;
      in_q.last_byte      <= s_axis_tlast;
      in_q.segment_length <= s_axis_tdata[24:8];
      in_q.closing        <= s_axis_tdata[25];
    end
  end

  wsfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_q),
    .push_o (push)
  );

  wsfr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (fire),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Output beat packing
  assign m_axis_tdata = {3'b000, res.pong_length, res.report_error,
                         res.peer_code, res.disconnect_code,
                         res.status, res.out_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.verdict_last;

endmodule

### sim/websocket_frame_receiver_tb.sv
// Self-checking testbench for websocket_frame_receiver: directed header cases,
// then random frames, broken headers and loose bytes, checked beat by beat against a behavioral parser.
// Depends on wsfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module websocket_frame_receiver_tb;
  import wsfr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandBeats  = 600;
  localparam int unsigned CalmBeats  = 80;

  // One row of the directed table; typed rows carry the verdict inline
  typedef struct {
    logic [7:0]      rx;
    bit              first;
    bit              last;
    logic [PosW-1:0] seg_len;
    bit              closing;
    bit              typed;
    status_e         st;
    logic [15:0]     disc;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Handshake signals as seen at the falling edge, used at the next rising edge
  logic        s_rdy_s = 1'b0;
  logic        m_vld_s = 1'b0;
  logic        m_rdy_s = 1'b0;
  logic [55:0] m_data_s = '0;
  logic [1:0]  m_user_s = '0;
  logic        m_last_s = 1'b0;

  result_t     ws_results_due[$];
  dir_row_t    dir_tbl[$];
  logic [7:0]  seg_q[$];
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt = 0;
  int          fails = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  // Parser state mirror
  logic [PosW-1:0] pos_r;
  logic [3:0]      op_r;
  logic [6:0]      len7_r;
  logic [15:0]     len16_r;
  logic [31:0]     key_r;
  status_e         err_r;
  logic [15:0]     peer_r;
  logic [PosW-1:0] seg_len_r;
  logic            closing_r;

  websocket_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    s_rdy_s  = s_axis_tready;
    m_vld_s  = m_axis_tvalid;
    m_rdy_s  = m_axis_tready;
    m_data_s = m_axis_tdata;
    m_user_s = m_axis_tuser;
    m_last_s = m_axis_tlast;
  end

  // Header length for the 7-bit length code seen so far
  function automatic logic [3:0] hdr_bytes(logic [6:0] len7);
    return (len7 == LenExt16) ? HdrExt : HdrShort;
  endfunction

  function automatic logic [15:0] close_code_of(status_e st);
    case (st)
      ST_OK, ST_NEED_MORE:      return CloseNone;
      ST_FIN_CLEAR, ST_TOO_BIG: return CloseTooBig;
      ST_UNEXP_OPCODE:          return CloseBadData;
      default:                  return CloseProtocol;
    endcase
  endfunction

  function automatic result_t payload_beat(kind_e k, logic [7:0] ob);
    result_t r;
    r = '0;
    r.kind = k;
    r.out_byte = ob;
    return r;
  endfunction

  function automatic in_beat_t mk_beat(logic [7:0] rx, bit first, bit last,
                                       logic [PosW-1:0] len, bit closing);
    in_beat_t b;
    b.rx_byte = rx;
    b.first_byte = first;
    b.last_byte = last;
    b.segment_length = len;
    b.closing = closing;
    return b;
  endfunction

  function automatic dir_row_t mk_row(logic [7:0] rx, bit first, bit last,
                                      logic [PosW-1:0] len, bit closing, bit typed,
                                      status_e st, logic [15:0] disc);
    dir_row_t r;
    r.rx = rx;
    r.first = first;
    r.last = last;
    r.seg_len = len;
    r.closing = closing;
    r.typed = typed;
    r.st = st;
    r.disc = disc;
    return r;
  endfunction

  // Parse one accepted byte and queue the beats it must produce
  task automatic parse_ws_byte(input in_beat_t b);
    logic [PosW-1:0] pos;
    logic [PosW-1:0] idx;
    logic [PosW-1:0] pay_len;
    logic [3:0]      hdr;
    logic [3:0]      op;
    logic [7:0]      kb;
    logic [7:0]      u;
    result_t         v;
    status_e         st;
    if (b.first_byte) begin
      pos_r = '0;
      op_r = '0;
      len7_r = '0;
      len16_r = '0;
      key_r = '0;
      err_r = ST_OK;
      peer_r = CloseNormal;
      seg_len_r = b.segment_length;
      closing_r = b.closing;
    end
    pos = pos_r;
    hdr = hdr_bytes(len7_r);

    if (err_r == ST_OK) begin
      if (pos == 0) begin
        op = b.rx_byte[3:0];
        op_r = op;
        if (seg_len_r < PosW'(HdrShort)) err_r = ST_TOO_SMALL;
        else if ((b.rx_byte & RsvMask) != 8'h00) err_r = ST_RSV_BITS;
        else if (!b.rx_byte[7]) err_r = ST_FIN_CLEAR;
        else if ((op >= OpRsvDataLo && op <= OpRsvDataHi) || op >= OpRsvCtrlLo)
          err_r = ST_RSV_OPCODE;
        else if (op <= OpText) err_r = ST_UNEXP_OPCODE;
      end else if (pos == 1) begin
        len7_r = b.rx_byte[6:0];
        if (!b.rx_byte[7]) err_r = ST_UNMASKED;
        else if (len7_r == LenExt64) err_r = ST_TOO_BIG;
        else if (len7_r == LenExt16) begin
          if (op_r != OpBinary) err_r = ST_LONG_CONTROL;
          else if (seg_len_r < ExtSegMin) err_r = ST_NEED_MORE;
        end
      end else if (hdr == HdrExt && pos < 4) begin
        len16_r = {len16_r[7:0], b.rx_byte};
        if (pos == 3 && (len16_r < ExtLenMin ||
                         int'(seg_len_r) < int'(HdrExt) + int'(len16_r)))
          err_r = ST_LEN_MISMATCH;
      end else if (pos < PosW'(hdr)) begin
        key_r = {key_r[23:0], b.rx_byte};
        if (pos == PosW'(hdr) - 1 && key_r == 32'd0) err_r = ST_ZERO_MASK;
      end else begin
        // payload: unmask with the key byte for this offset
        idx = pos - PosW'(hdr);
        kb = key_r[8*(3-idx[1:0]) +: 8];
        u = b.rx_byte ^ kb;
        if (!closing_r && op_r == OpBinary) ws_results_due.push_back(payload_beat(KIND_MESSAGE, u));
        else if (!closing_r && op_r == OpPing) ws_results_due.push_back(payload_beat(KIND_PONG, u));
        if (op_r == OpClose && int'(seg_len_r) >= int'(hdr) + 2) begin
          if (idx == 0) peer_r = {u, 8'h00};
          else if (idx == 1) peer_r = {peer_r[15:8], u};
        end
      end
    end

    if (pos_r != PosMax) pos_r = pos_r + 1'b1;

    // final byte: segment verdict
    if (b.last_byte) begin
      if (err_r == ST_OK && (pos_r < 2 || pos_r < PosW'(hdr_bytes(len7_r))))
        err_r = ST_TOO_SMALL;
      st = err_r;
      v = '0;
      v.kind = KIND_VERDICT;
      v.status = st;
      v.peer_code = peer_r;
      v.verdict_last = 1'b1;
      if (st != ST_OK) begin
        v.disconnect_code = close_code_of(st);
      end else if (op_r == OpClose) begin
        v.disconnect_code = CloseNormal;
        v.report_error = (peer_r != CloseNormal);
      end else if (op_r == OpPing && !closing_r) begin
        pay_len = seg_len_r - PosW'(hdr_bytes(len7_r));
        v.pong_length = pay_len[7:0];
      end
      ws_results_due.push_back(v);
    end
  endtask

  // Offer one byte, with an occasional gap ahead of it, and wait for acceptance
  task automatic send_beat(input in_beat_t b);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, b.closing, b.segment_length, b.rx_byte};
    s_axis_tuser  <= b.first_byte;
    s_axis_tlast  <= b.last_byte;
    @(posedge clk_i);
    while (!s_rdy_s) @(posedge clk_i);
    parse_ws_byte(b);
    beats_sent++;
  endtask

  // Send the bytes in seg_q as one segment
  task automatic send_seg(input logic [PosW-1:0] len, input bit closing, input bit ends);
    int n;
    n = seg_q.size();
    for (int i = 0; i < n; i++)
      send_beat(mk_beat(seg_q[i], i == 0, ends && i == n - 1, len, closing));
  endtask

  // Build a masked frame in seg_q, at times with a zero key or a wrong length; bulk gives a long 16-bit binary frame
  task automatic build_frame(input bit bulk, output logic [PosW-1:0] len, output bit closing);
    logic [3:0]  op;
    logic [31:0] key;
    logic [7:0]  u;
    int          pick;
    int          plen;
    bit          ext;
    pick = $urandom_range(0, 9);
    op = (pick < 5 || bulk) ? OpBinary : (pick < 8) ? OpPing : OpClose;
    ext = bulk || (op == OpBinary && $urandom_range(0, 29) == 0);
    if (bulk) plen = 130;
    else if (ext) plen = $urandom_range(126, 180);
    else if (op == OpClose && $urandom_range(0, 1) == 0) plen = 2;
    else if ($urandom_range(0, 7) == 0) plen = $urandom_range(0, 125);
    else plen = $urandom_range(0, 12);
    key = $urandom();
    if (!bulk && $urandom_range(0, 19) == 0) key = 32'd0;
    if (bulk && key == 32'd0) key = 32'h0000_0001;
    seg_q.delete();
    seg_q.push_back({4'h8, op});
    seg_q.push_back(ext ? {1'b1, LenExt16} : 8'(8'h80 | plen));
    if (ext) begin
      seg_q.push_back(8'(plen >> 8));
      seg_q.push_back(8'(plen));
    end
    for (int k = 0; k < 4; k++) seg_q.push_back(key[8*(3-k) +: 8]);
    for (int i = 0; i < plen; i++) begin
      u = 8'($urandom_range(0, 255));
      // close frames often carry a normal close code
      if (op == OpClose && i < 2 && pick == 8) u = (i == 0) ? 8'h03 : 8'hE8;
      seg_q.push_back(u ^ 8'(key >> (24 - 8 * (i % 4))));
    end
    len = PosW'(seg_q.size());
    if (!bulk && $urandom_range(0, 9) == 0) len = PosW'($urandom_range(0, seg_q.size() + 4));
    closing = !bulk && $urandom_range(0, 3) == 0;
  endtask

  // Output checker
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (m_vld_s && m_rdy_s) begin
      if (ws_results_due.size() == 0) begin
        $error("result beat with nothing pending: tdata %h tuser %0d", m_data_s, m_user_s);
        fails++;
      end else begin
        want = ws_results_due.pop_front();
        check_field("kind", want.kind, m_user_s);
        check_field("out_byte", want.out_byte, m_data_s[7:0]);
        check_field("status", want.status, m_data_s[11:8]);
        check_field("disconnect_code", want.disconnect_code, m_data_s[27:12]);
        check_field("peer_code", want.peer_code, m_data_s[43:28]);
        check_field("report_error", want.report_error, m_data_s[44]);
        check_field("pong_length", want.pong_length, m_data_s[52:45]);
        check_field("verdict_last", want.verdict_last, m_last_s);
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $error("timeout, %0d result beats outstanding", ws_results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sink: random ready bursts, one long hold on request, always ready when calm
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Source
  initial begin
    logic [PosW-1:0] len;
    bit              cl;
    bit              held;
    bit              paused;
    int              pick;
    int unsigned     dir_n;
    result_t         v;
    held = 1'b0;
    paused = 1'b0;

    // header checks, one segment per group
    dir_tbl.push_back(mk_row(8'h00, 1, 1, 17'd0,     0, 1, ST_TOO_SMALL,    CloseProtocol));
    dir_tbl.push_back(mk_row(8'hF2, 1, 1, 17'd6,     0, 1, ST_RSV_BITS,     CloseProtocol));
    dir_tbl.push_back(mk_row(8'h02, 1, 1, 17'd6,     0, 1, ST_FIN_CLEAR,    CloseTooBig));
    dir_tbl.push_back(mk_row(8'h8F, 1, 1, 17'd65543, 1, 1, ST_RSV_OPCODE,   CloseProtocol));
    dir_tbl.push_back(mk_row(8'h81, 1, 1, 17'd6,     0, 1, ST_UNEXP_OPCODE, CloseBadData));
    dir_tbl.push_back(mk_row(8'h82, 1, 0, 17'd6,     0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'h05, 0, 1, 17'd6,     0, 1, ST_UNMASKED,     CloseProtocol));
    // 64-bit length refused
    dir_tbl.push_back(mk_row(8'h82, 1, 0, 17'd6,     0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'hFF, 0, 1, 17'd6,     0, 1, ST_TOO_BIG,      CloseTooBig));
    // 16-bit length on a ping
    dir_tbl.push_back(mk_row(8'h89, 1, 0, 17'd6,     0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'hFE, 0, 1, 17'd6,     0, 1, ST_LONG_CONTROL, CloseProtocol));
    // 16-bit length in too short a segment
    dir_tbl.push_back(mk_row(8'h82, 1, 0, 17'd10,    0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'hFE, 0, 1, 17'd10,    0, 1, ST_NEED_MORE,    CloseNone));
    // 16-bit length below 126
    dir_tbl.push_back(mk_row(8'h82, 1, 0, 17'd200,   0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'hFE, 0, 0, 17'd200,   0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'h00, 0, 0, 17'd200,   0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'h7D, 0, 1, 17'd200,   0, 1, ST_LEN_MISMATCH, CloseProtocol));
    // all-zero key on a close frame
    dir_tbl.push_back(mk_row(8'h88, 1, 0, 17'd6,     1, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'h80, 0, 0, 17'd6,     1, 0, ST_OK,           CloseNone));
    for (int i = 0; i < 3; i++)
      dir_tbl.push_back(mk_row(8'h00, 0, 0, 17'd6,   1, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'h00, 0, 1, 17'd6,     1, 1, ST_ZERO_MASK,    CloseProtocol));
    // segment ends inside the header
    dir_tbl.push_back(mk_row(8'h82, 1, 0, 17'd8,     0, 0, ST_OK,           CloseNone));
    dir_tbl.push_back(mk_row(8'h84, 0, 1, 17'd8,     0, 1, ST_TOO_SMALL,    CloseProtocol));
    // stray byte after the final one
    dir_tbl.push_back(mk_row(8'h55, 0, 0, 17'd0,     0, 0, ST_OK,           CloseNone));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_tbl[i]) begin
      send_beat(mk_beat(dir_tbl[i].rx, dir_tbl[i].first, dir_tbl[i].last,
                        dir_tbl[i].seg_len, dir_tbl[i].closing));
      if (dir_tbl[i].typed) begin
        v = ws_results_due.pop_back();
        v.status = dir_tbl[i].st;
        v.disconnect_code = dir_tbl[i].disc;
        v.peer_code = CloseNormal;
        v.report_error = 1'b0;
        v.pong_length = 8'd0;
        ws_results_due.push_back(v);
      end
    end
    dir_n = beats_sent;

    // random part
    while (beats_sent < dir_n + RandBeats) begin
      if (beats_sent >= dir_n + RandBeats - CalmBeats) calm = 1'b1;
      if (!held && beats_sent >= dir_n + 150) begin
        // stall the sink while a long frame streams in
        held = 1'b1;
        hold_req = 1'b1;
        build_frame(1'b1, len, cl);
        send_seg(len, cl, 1'b1);
      end
      if (!paused && beats_sent >= dir_n + 350) begin
        // let the receiver drain completely
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (ws_results_due.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        build_frame(1'b0, len, cl);
        send_seg(len, cl, $urandom_range(0, 15) != 0);
      end else if (pick < 90) begin
        // broken header
        seg_q.delete();
        repeat ($urandom_range(1, 6)) seg_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) seg_q[0] = {4'h8, 4'($urandom_range(0, 15))};
        len = ($urandom_range(0, 3) == 0) ? PosW'($urandom_range(0, 65543))
                                          : PosW'($urandom_range(0, 20));
        send_seg(len, 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        // loose bytes with random side-band
        repeat ($urandom_range(1, 4))
          send_beat(mk_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), PosW'($urandom_range(0, 65543)),
                            1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 2))
          send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                            PosW'($urandom_range(0, 255)), 1'b0));
      end
    end

    calm = 1'b1;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ws_results_due.size() != 0);
    repeat (10) @(posedge clk_i);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
